### hw/rtl/crs_pkg.sv
`timescale 1ns / 1ps
package crs_pkg;

  localparam int unsigned CoordW = 26;  // signed Q.17 coordinate
  localparam logic [62:0] SMax = {63{1'b1}};

  typedef logic signed [63:0] sval_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_NORMAL_TIME = 3'd0,
    REG_COEF_LINEAR = 3'd1,
    REG_COEF_QUAD   = 3'd2,
    REG_COEF_OFFSET = 3'd3,
    REG_OFFSET_HALF = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [31:0]        t0;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic signed [31:0] c1;
    logic               half;
  } crs_cfg_t;

  // magnitude of a signed 64-bit value
  function automatic logic [63:0] mag64(input sval_t v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

  // saturate an unsigned magnitude to SMAX
  function automatic logic [62:0] sat_mag(input logic [127:0] p, input int unsigned s);
    logic [127:0] q;
    q = p >> s;
    sat_mag = (q[127:63] != '0) ? SMax : q[62:0];
  endfunction

  // apply sign to a saturated magnitude
  function automatic sval_t sgn(input logic [62:0] m, input logic neg);
    sgn = neg ? -sval_t'({1'b0, m}) : sval_t'({1'b0, m});
  endfunction

  // symmetric saturating add
  function automatic sval_t sadd(input sval_t a, input sval_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) sadd = sval_t'({1'b0, SMax});
    else if (s < -65'sh0_7FFF_FFFF_FFFF_FFFF) sadd = -sval_t'({1'b0, SMax});
    else sadd = s[63:0];
  endfunction

endpackage

### hw/rtl/crs_sqrt.sv
`timescale 1ns / 1ps
// Pipelined restoring floor square root of a Q.32 value into Q.24,
// one result bit per stage. Carries a sideband tag along.
module crs_sqrt
  import crs_pkg::*;
#(
  parameter int TagW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [63:0]     in_val,
  input  logic [TagW-1:0] in_tag,
  output logic            out_vld,
  output logic [39:0]     out_root,
  output logic [TagW-1:0] out_tag
);
  localparam int Stages = 40;  // 80-bit operand, two bits per stage

  logic [79:0]     op_val;
  logic            op_big;
  logic [79:0]     rem_r  [Stages];
  logic [79:0]     root_r [Stages];
  logic [79:0]     val_r  [Stages];
  logic            big_r  [Stages];
  logic [TagW-1:0] tag_r  [Stages];
  logic            vld_r  [Stages];

  // pick operand scaling (small values shifted by 16, large by 0)
  assign op_big = (in_val[63:48] != '0);
  assign op_val = op_big ? {16'd0, in_val} : {in_val, 16'd0};

  // one bit-pair per stage, rolling the operand left
  for (genvar i = 0; i < Stages; i++) begin : g_st
    logic [79:0]     rem_in, root_in, val_in;
    logic            big_in, vld_in;
    logic [TagW-1:0] tag_in;
    logic [79:0]     rem_nxt, root_nxt, trial;
    if (i == 0) begin : g_head
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = op_val;
      assign big_in  = op_big;
      assign vld_in  = in_vld;
      assign tag_in  = in_tag;
    end else begin : g_tail
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign val_in  = val_r[i-1];
      assign big_in  = big_r[i-1];
      assign vld_in  = vld_r[i-1];
      assign tag_in  = tag_r[i-1];
    end
    always_comb begin
      rem_nxt  = {rem_in[77:0], val_in[79:78]};
      trial    = {root_in[77:0], 2'b01};
      root_nxt = {root_in[78:0], 1'b0};
      if (rem_nxt >= trial) begin
        rem_nxt  = rem_nxt - trial;
        root_nxt = {root_in[78:0], 1'b1};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
      if (en) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        val_r[i]  <= {val_in[77:0], 2'b00};
        big_r[i]  <= big_in;
        tag_r[i]  <= tag_in;
      end
    end
  end

  // large operands: root in Q.16 scaled by 256
  assign out_root = big_r[Stages-1] ? {root_r[Stages-1][31:0], 8'd0} : root_r[Stages-1][39:0];
  assign out_vld  = vld_r[Stages-1];
  assign out_tag  = tag_r[Stages-1];
endmodule

### hw/rtl/crs_traveltime_surface.sv
`timescale 1ns / 1ps
// Pipeline from the accepting edge to out_tvalid: six arithmetic stages,
// a 40-stage root, two product stages, one sum stage, a 40-stage root, output register.
// Throughput: one item per cycle; the whole pipe advances unless the output register is full
// and not taken.
// Reset: synchronous active-low rst_n clears valid bits and loads register defaults
// (offset_is_half = 1, coefficients 0).
module crs_traveltime_surface
  import crs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [23:0] midpoint_distance, [46:24] offset, [47] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] traveltime
  output logic [31:0] out_tdata,
  // [0] radicand_negative
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  crs_cfg_t cfg_r;
  logic     en;
  logic [2:0] ridx;

  assign ridx = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{t0: '0, a1: '0, a2: '0, c1: '0, half: 1'b1};
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (ridx)
        REG_NORMAL_TIME: cfg_r.t0   <= cfg_pwdata;
        REG_COEF_LINEAR: cfg_r.a1   <= cfg_pwdata;
        REG_COEF_QUAD:   cfg_r.a2   <= cfg_pwdata;
        REG_COEF_OFFSET: cfg_r.c1   <= cfg_pwdata;
        REG_OFFSET_HALF: cfg_r.half <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (ridx)
      REG_NORMAL_TIME: cfg_prdata = cfg_r.t0;
      REG_COEF_LINEAR: cfg_prdata = cfg_r.a1;
      REG_COEF_QUAD:   cfg_prdata = cfg_r.a2;
      REG_COEF_OFFSET: cfg_prdata = cfg_r.c1;
      REG_OFFSET_HALF: cfg_prdata = {31'd0, cfg_r.half};
      default:         cfg_prdata = '0;
    endcase
  end

  // coefficient magnitudes
  logic [31:0] a1_mag, a2_mag, c1_mag;
  assign a1_mag = 32'(mag64(64'(cfg_r.a1)));
  assign a2_mag = 32'(mag64(64'(cfg_r.a2)));
  assign c1_mag = 32'(mag64(64'(cfg_r.c1)));

  // whole pipe stalls only when output register is held
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // S1: coordinates in Q.17, three lanes (m, m-h, m+h) and h
  logic               v1_r;
  logic signed [CoordW-1:0] x1_r [3];
  logic [24:0]        h1_r;
  logic signed [CoordW-1:0] m_nxt;
  logic [24:0] h_nxt;
  assign m_nxt = CoordW'($signed(in_tdata[23:0])) <<< 1;
  assign h_nxt = cfg_r.half ? {1'b0, in_tdata[46:24], 1'b0} : {2'b0, in_tdata[46:24]};
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
    if (en) begin
      x1_r[0] <= m_nxt;
      x1_r[1] <= m_nxt - CoordW'($signed({1'b0, h_nxt}));
      x1_r[2] <= m_nxt + CoordW'($signed({1'b0, h_nxt}));
      h1_r    <= h_nxt;
    end
  end

  // S2: a1*x (Q.24) and x^2, h^2
  logic v2_r;
  sval_t ax2_r [3];
  logic [49:0] xx2_r [3];
  logic [49:0] hh2_r;
  logic [24:0] xm1 [3];
  logic [56:0] axp1 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xm1[i]  = 25'(mag64(64'(x1_r[i])));
      axp1[i] = a1_mag * xm1[i];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ax2_r[i] <= sgn(sat_mag(128'(axp1[i]), 17), cfg_r.a1[31] != x1_r[i][CoordW-1]);
        xx2_r[i] <= xm1[i] * xm1[i];
      end
      hh2_r <= h1_r * h1_r;
    end
  end

  // S3: u = t0 + a1x ; partial products of a2*x^2 and c1*h^2
  logic v3_r;
  sval_t u3_r [3];
  logic [56:0] qlo3_r [3];
  logic [56:0] qhi3_r [3];
  logic        qn3_r [3];
  logic [56:0] clo3_r, chi3_r;
  logic        cn3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u3_r[i]   <= sadd(sval_t'({32'd0, cfg_r.t0}), ax2_r[i]);
        qlo3_r[i] <= a2_mag * xx2_r[i][24:0];
        qhi3_r[i] <= a2_mag * xx2_r[i][49:25];
        qn3_r[i]  <= cfg_r.a2[31];
      end
      clo3_r <= c1_mag * hh2_r[24:0];
      chi3_r <= c1_mag * hh2_r[49:25];
      cn3_r  <= cfg_r.c1[31];
    end
  end

  // S4: combine a2*x^2, c1*h^2 ; partial products of u^2 (|u| < 2^40)
  logic v4_r;
  logic [39:0] um3 [3];
  logic [39:0] ull4_r [3];
  logic [39:0] ulh4_r [3];
  logic [39:0] uhh4_r [3];
  sval_t q4_r [3];
  sval_t c4_r;
  always_comb begin
    for (int i = 0; i < 3; i++) um3[i] = 40'(mag64(u3_r[i]));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ull4_r[i] <= um3[i][19:0] * um3[i][19:0];
        ulh4_r[i] <= um3[i][19:0] * um3[i][39:20];
        uhh4_r[i] <= um3[i][39:20] * um3[i][39:20];
        q4_r[i]   <= sgn(sat_mag({46'd0, qhi3_r[i], 25'd0} + {71'd0, qlo3_r[i]}, 26),
                         qn3_r[i]);
      end
      c4_r <= sgn(sat_mag({46'd0, chi3_r, 25'd0} + {71'd0, clo3_r}, 26), cn3_r);
    end
  end

  // S5: u^2
  logic v5_r;
  sval_t uu5_r [3];
  sval_t q5_r [3];
  sval_t c5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        uu5_r[i] <= sgn(sat_mag({48'd0, uhh4_r[i], 40'd0} + {67'd0, ulh4_r[i], 21'd0}
                                + {88'd0, ull4_r[i]}, 16), 1'b0);
      end
      q5_r <= q4_r;
      c5_r <= c4_r;
    end
  end

  // S6: F = u^2 + a2 x^2 ; partial sum fm + c1 h^2 ; sign check
  logic v6_r;
  sval_t f6_r [3];
  sval_t p6_r;
  logic  bad6;
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
    if (en) begin
      for (int i = 0; i < 3; i++) f6_r[i] <= sadd(uu5_r[i], q5_r[i]);
      p6_r <= sadd(sadd(uu5_r[0], q5_r[0]), c5_r);
    end
  end
  assign bad6 = (f6_r[1] < 0 && f6_r[2] > 0) || (f6_r[1] > 0 && f6_r[2] < 0);

  // root of |F(m-h)| and |F(m+h)|, partial sum and flag ride along
  localparam int TagW1 = 65;
  logic        vs1, vs1b;
  logic [39:0] rl, rr;
  logic [TagW1-1:0] tg1, tg1b;
  crs_sqrt #(.TagW(TagW1)) u_sqrt_l (
    .clk, .rst_n, .en, .in_vld(v6_r), .in_val(mag64(f6_r[1])),
    .in_tag({bad6, p6_r}), .out_vld(vs1), .out_root(rl), .out_tag(tg1));
  crs_sqrt #(.TagW(TagW1)) u_sqrt_r (
    .clk, .rst_n, .en, .in_vld(v6_r), .in_val(mag64(f6_r[2])),
    .in_tag({bad6, p6_r}), .out_vld(vs1b), .out_root(rr), .out_tag(tg1b));

  // S7: partial products of the roots
  logic v7_r;
  logic [39:0] pll7_r, plh7_r, phl7_r, phh7_r;
  logic [TagW1-1:0] t7_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (en) v7_r <= vs1;
    if (en) begin
      pll7_r <= rl[19:0] * rr[19:0];
      plh7_r <= rl[19:0] * rr[39:20];
      phl7_r <= rl[39:20] * rr[19:0];
      phh7_r <= rl[39:20] * rr[39:20];
      t7_r   <= tg1;
    end
  end

  // S8: product of roots, Q.32
  logic v8_r;
  logic [62:0] g8_r;
  logic [TagW1-1:0] t8_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else if (en) v8_r <= v7_r;
    if (en) begin
      g8_r <= sat_mag({48'd0, phh7_r, 40'd0} + {68'd0, plh7_r, 20'd0}
                      + {68'd0, phl7_r, 20'd0} + {88'd0, pll7_r}, 16);
      t8_r <= t7_r;
    end
  end

  // S9: final sum, halve
  logic v9_r;
  logic [63:0] s9_r;
  logic n9_r;
  sval_t sum9;
  assign sum9 = sadd(sval_t'(t8_r[63:0]), sval_t'({1'b0, g8_r}));
  always_ff @(posedge clk) begin
    if (!rst_n) v9_r <= 1'b0;
    else if (en) v9_r <= v8_r;
    if (en) begin
      n9_r <= t8_r[64] || sum9 < 0;
      s9_r <= {1'b0, sum9[63:1]};
    end
  end

  // final root
  logic vf;
  logic [39:0] rf;
  logic tf;
  crs_sqrt #(.TagW(1)) u_sqrt_f (
    .clk, .rst_n, .en, .in_vld(v9_r), .in_val(n9_r ? 64'd0 : s9_r),
    .in_tag(n9_r), .out_vld(vf), .out_root(rf), .out_tag(tf));

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (en) out_tvalid <= vf;
    if (en) begin
      out_tuser <= tf;
      out_tdata <= tf ? 32'd0 : ((rf[39:32] != '0) ? 32'hFFFF_FFFF : rf[31:0]);
    end
  end

  // flagged items carry zero time
  a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0) else $error("flag without zero time");
  // held output stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("lost item");
  // lanes stay in step
  a_lane: assert property (@(posedge clk) disable iff (!rst_n)
    vs1 == vs1b) else $error("root lanes diverged");
  // both lanes carry the same sideband
  a_tag: assert property (@(posedge clk) disable iff (!rst_n)
    vs1 |-> tg1 == tg1b) else $error("root lane tags diverged");
endmodule
